@@ rtl/core/krt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_pkg: shared types and constants of the keyed record table
// Record layout, command and status codes, controller states and sizes.
// ----------------------------------------------------------------------------
package krt_pkg;

	localparam int TableDepth = 32;
	localparam int MaxResults = 32;
	localparam int IdxW = $clog2(TableDepth);
	localparam int CntW = $clog2(TableDepth + 1);
	localparam int ResW = $clog2(MaxResults + 1);

	typedef enum logic [2:0] {
		CMD_SAVE     = 3'd0,
		CMD_FIND_ID  = 3'd1,
		CMD_FIND_SYM = 3'd2,
		CMD_LIST     = 3'd3,
		CMD_REMOVE   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_MISS     = 2'd1,
		ST_CONFLICT = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH,
		S_APPLY,
		S_COMPACT
	} state_t;

	typedef struct packed {
		logic [31:0] id;
		logic [63:0] symbol;
		logic [31:0] channel;
	} entry_t;

	typedef struct packed {
		status_t status;
		entry_t  rec;
		logic    last;
	} result_t;

	function automatic result_t empty_result(status_t st);
		result_t r;
		r.status = st;
		r.rec    = '0;
		r.last   = 1'b1;
		return r;
	endfunction

	function automatic result_t entry_result(entry_t e, logic last);
		result_t r;
		r.status = ST_OK;
		r.rec    = e;
		r.last   = last;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/krt_ifs.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_ifs: request and response channels of the keyed record table
// Valid/ready channels; a transfer happens when valid and ready are both high.
// ----------------------------------------------------------------------------
interface krt_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  cmd;
	logic [31:0] key_id;
	logic [63:0] key_symbol;
	logic [31:0] key_channel;

	modport source (output valid, cmd, key_id, key_symbol, key_channel, input ready);
	modport sink (input valid, cmd, key_id, key_symbol, key_channel, output ready);
endinterface

interface krt_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic        record_valid;
	logic [31:0] rec_id;
	logic [63:0] rec_symbol;
	logic [31:0] rec_channel;
	logic        last;

	modport source (output valid, status, record_valid, rec_id, rec_symbol, rec_channel,
		last, input ready);
	modport sink (input valid, status, record_valid, rec_id, rec_symbol, rec_channel,
		last, output ready);
endinterface
`default_nettype wire

@@ rtl/core/krt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_cell: one record slot of the rotating table
// Takes the record of its neighbor whenever the ring shifts.
// ----------------------------------------------------------------------------
module krt_cell import krt_pkg::*; (
	input  wire logic   clk,
	input  wire logic   shift,
	input  wire entry_t d,
	output entry_t      q
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= d;
		end
	end

	assign q = entry_q;

endmodule
`default_nettype wire

@@ rtl/core/keyed_record_table_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Flow: a request is scanned in one rotation of the ring (which halts while the
// response side stalls), then its final response is registered in S_FINISH.
// An accepted save or a remove that hits adds a second rotation to write or close the gap.
// Requests: none is taken until the previous one is done, and the ring of record cells
// rotates once per pass.
// Reset: arst_n clears the count, state and response valid; record cells are not cleared.
// ----------------------------------------------------------------------------
// keyed_record_table_core: ordered record table with id, symbol and channel keys
// The records sit in a ring of cells; the head cell is examined as the ring rotates.
// ----------------------------------------------------------------------------
module keyed_record_table_core import krt_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	krt_req_if.sink   req,
	krt_rsp_if.source rsp
);

	entry_t  cell_q [TableDepth];
	entry_t  tail_d;
	logic    shift;

	state_t  state_q, state_d;
	logic [IdxW-1:0] k_q, k_d, pos_q, pos_d;
	logic [CntW-1:0] count_q, count_d;
	logic [2:0]      cmd_q, cmd_d;
	entry_t  key_q, key_d;
	logic    hit_q, hit_d, conflict_q, conflict_d, pend_v_q, pend_v_d;
	entry_t  hit_rec_q, hit_rec_d, pend_q, pend_d;
	logic [ResW-1:0] taken_q, taken_d;
	logic    out_v_q, out_load;
	result_t out_q, out_d;

	logic slot_free, in_range, last_k, id_eq, sym_eq, chan_eq, sel_eq;
	entry_t head, nxt;

	for (genvar i = 0; i < TableDepth; i++) begin : g_cell
		entry_t d;
		if (i == TableDepth - 1) begin : g_tail
			assign d = tail_d;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		krt_cell u_cell (.clk(clk), .shift(shift), .d(d), .q(cell_q[i]));
	end

	assign head      = cell_q[0];
	assign nxt       = cell_q[1];
	assign slot_free = !out_v_q || rsp.ready;
	assign in_range  = CntW'(k_q) < count_q;
	assign last_k    = k_q == IdxW'(TableDepth - 1);
	assign id_eq     = head.id == key_q.id;
	assign sym_eq    = head.symbol == key_q.symbol;
	assign chan_eq   = head.channel == key_q.channel;
	assign sel_eq    = (cmd_q == CMD_FIND_SYM) ? sym_eq : id_eq;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		k_q        <= k_d;
		pos_q      <= pos_d;
		cmd_q      <= cmd_d;
		key_q      <= key_d;
		hit_q      <= hit_d;
		conflict_q <= conflict_d;
		hit_rec_q  <= hit_rec_d;
		pend_v_q   <= pend_v_d;
		pend_q     <= pend_d;
		taken_q    <= taken_d;
		if (out_load) begin
			out_q <= out_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		k_d        = k_q;
		pos_d      = pos_q;
		count_d    = count_q;
		cmd_d      = cmd_q;
		key_d      = key_q;
		hit_d      = hit_q;
		conflict_d = conflict_q;
		hit_rec_d  = hit_rec_q;
		pend_v_d   = pend_v_q;
		pend_d     = pend_q;
		taken_d    = taken_q;
		out_load   = 1'b0;
		out_d      = out_q;
		shift      = 1'b0;
		tail_d     = head;
		req.ready  = 1'b0;

		case (state_q)
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					cmd_d       = req.cmd;
					key_d       = '{id: req.key_id, symbol: req.key_symbol,
						channel: req.key_channel};
					k_d         = '0;
					hit_d       = 1'b0;
					conflict_d  = 1'b0;
					pend_v_d    = 1'b0;
					taken_d     = '0;
					state_d     = S_SCAN;
				end
			end
			S_SCAN: begin
				// The ring only moves when the response register is free.
				shift = slot_free;
				if (slot_free) begin
					if (in_range) begin
						if (sym_eq && !id_eq) begin
							conflict_d = 1'b1;
						end
						if (!hit_q && sel_eq) begin
							hit_d     = 1'b1;
							pos_d     = k_q;
							hit_rec_d = head;
						end
						if (cmd_q == CMD_LIST && chan_eq && taken_q < ResW'(MaxResults)) begin
							// Hold one match back so the final one can carry last.
							if (pend_v_q) begin
								out_load = 1'b1;
								out_d    = entry_result(pend_q, 1'b0);
							end
							pend_v_d = 1'b1;
							pend_d   = head;
							taken_d  = taken_q + ResW'(1);
						end
					end
					k_d = k_q + IdxW'(1);
					if (last_k) begin
						k_d     = '0;
						state_d = S_FINISH;
					end
				end
			end
			S_FINISH: begin
				if (slot_free) begin
					out_load = 1'b1;
					out_d    = empty_result(ST_MISS);
					state_d  = S_IDLE;
					case (cmd_q)
						CMD_SAVE: begin
							if (conflict_q) begin
								out_d = empty_result(ST_CONFLICT);
							end else if (hit_q) begin
								out_d   = entry_result(key_q, 1'b1);
								state_d = S_APPLY;
							end else if (count_q == CntW'(TableDepth)) begin
								out_d = empty_result(ST_FULL);
							end else begin
								out_d   = entry_result(key_q, 1'b1);
								pos_d   = IdxW'(count_q);
								count_d = count_q + CntW'(1);
								state_d = S_APPLY;
							end
						end
						CMD_FIND_ID, CMD_FIND_SYM: begin
							if (hit_q) begin
								out_d = entry_result(hit_rec_q, 1'b1);
							end
						end
						CMD_LIST: begin
							if (pend_v_q) begin
								out_d = entry_result(pend_q, 1'b1);
							end
						end
						CMD_REMOVE: begin
							if (hit_q) begin
								out_d   = entry_result(hit_rec_q, 1'b1);
								count_d = count_q - CntW'(1);
								state_d = S_COMPACT;
							end
						end
						default: begin
							out_d = empty_result(ST_MISS);
						end
					endcase
				end
			end
			S_APPLY: begin
				shift = 1'b1;
				if (k_q == pos_q) begin
					tail_d = key_q;
				end
				k_d = k_q + IdxW'(1);
				if (last_k) begin
					k_d     = '0;
					state_d = S_IDLE;
				end
			end
			S_COMPACT: begin
				// From the removed slot on, each slot takes its successor's record.
				shift = 1'b1;
				if (k_q >= pos_q) begin
					tail_d = nxt;
				end
				k_d = k_q + IdxW'(1);
				if (last_k) begin
					k_d     = '0;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = out_q.status;
	assign rsp.record_valid = out_q.rec.id != '0;
	assign rsp.rec_id       = out_q.rec.id;
	assign rsp.rec_symbol   = out_q.rec.symbol;
	assign rsp.rec_channel  = out_q.rec.channel;
	assign rsp.last         = out_q.last;

endmodule
`default_nettype wire

@@ rtl/core/krt_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// krt_checker: port-level checks of the keyed record table
// Watches the request and response channels of the top level.
// ----------------------------------------------------------------------------
module krt_checker import krt_pkg::*; (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        req_valid,
	input wire logic        req_ready,
	input wire logic        rsp_valid,
	input wire logic        rsp_ready,
	input wire logic [1:0]  rsp_status,
	input wire logic        rsp_record_valid,
	input wire logic [31:0] rsp_rec_id,
	input wire logic        rsp_last
);

	// A stalled response keeps its record id and last flag.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rec_id) && $stable(rsp_last))
		else $error("response changed while stalled");

	// Requests are taken one at a time.
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted in back-to-back cycles");

	// Only list responses come before the final one, and they always hit.
	a_mid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_last |-> rsp_status == ST_OK)
		else $error("non-final response without ok status");

	a_rec_valid: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp_record_valid == (rsp_rec_id != '0))
		else $error("record_valid does not match the record id");

endmodule

bind keyed_record_table_core krt_checker u_krt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.req_valid        (req.valid),
	.req_ready        (req.ready),
	.rsp_valid        (rsp.valid),
	.rsp_ready        (rsp.ready),
	.rsp_status       (rsp.status),
	.rsp_record_valid (rsp.record_valid),
	.rsp_rec_id       (rsp.rec_id),
	.rsp_last         (rsp.last)
);
`default_nettype wire
